FILE: sv/one_mismatch_string_matcher_macros.svh
// ---------------------------------------------------------------------------
// One-mismatch string matcher assertion macros
// Clocked property checks shared by the matcher RTL.
// ---------------------------------------------------------------------------
`ifndef ONE_MISMATCH_STRING_MATCHER_MACROS_SVH
`define ONE_MISMATCH_STRING_MATCHER_MACROS_SVH

// Check a property on every clock edge outside reset.
`define OMSM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define OMSM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/omsm_pkg.sv
// ---------------------------------------------------------------------------
// One-mismatch string matcher package
// Widths, command and result codes, and types shared by the matcher files.
// ---------------------------------------------------------------------------
package omsm_pkg;

  localparam int     MAX_PATTERN_DEF = 64;
  localparam longint MAX_TEXT_DEF    = 65536;

  localparam int CMD_W  = 2;
  localparam int CHAR_W = 8;
  localparam int POS_W  = 16;

  typedef logic [CMD_W-1:0] cmd_t;

  localparam cmd_t CMD_CLEAR  = 2'd0;
  localparam cmd_t CMD_APPEND = 2'd1;
  localparam cmd_t CMD_TEXT   = 2'd2;
  localparam cmd_t CMD_END    = 2'd3;

  localparam logic KIND_MATCH   = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef struct packed {
    cmd_t              cmd;
    logic [CHAR_W-1:0] ch;
  } item_t;

  // Window compare summary, capped at two differing bytes.
  typedef struct packed {
    logic diff_any;
    logic diff_multi;
  } cmp_t;

  typedef struct packed {
    logic             kind;
    logic [POS_W-1:0] position;
    logic             mismatches;
    logic             any_match;
    logic             position_overflow;
  } result_t;

endpackage

FILE: sv/omsm_if.sv
// ---------------------------------------------------------------------------
// One-mismatch string matcher channels
// Valid/ready channels for command items and result items.
// ---------------------------------------------------------------------------
interface omsm_in_if;
  import omsm_pkg::*;

  logic              valid;
  logic              ready;
  cmd_t              cmd;
  logic [CHAR_W-1:0] char_in;

  modport source (output valid, cmd, char_in, input ready);
  modport sink   (input valid, cmd, char_in, output ready);
endinterface

interface omsm_out_if;
  import omsm_pkg::*;

  logic             valid;
  logic             ready;
  logic             kind;
  logic [POS_W-1:0] position;
  logic             mismatches;
  logic             any_match;
  logic             position_overflow;

  modport source (output valid, kind, position, mismatches, any_match, position_overflow,
                  input ready);
  modport sink   (input valid, kind, position, mismatches, any_match, position_overflow,
                  output ready);
endinterface

FILE: sv/omsm_store.sv
// ---------------------------------------------------------------------------
// Pattern and text window store
// Holds the pattern newest-byte-first and the text window, and compares all
// window positions with the pattern in parallel.
// ---------------------------------------------------------------------------
module omsm_store #(
  parameter int MAX_PATTERN = omsm_pkg::MAX_PATTERN_DEF,
  parameter int LEN_W       = $clog2(omsm_pkg::MAX_PATTERN_DEF + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  omsm_pkg::item_t     item,
  output logic [LEN_W-1:0]    plen,
  output omsm_pkg::cmp_t      cmp
);
  import omsm_pkg::*;

  // pat[k] holds pattern byte plen-1-k, so it lines up with window entry k.
  logic [CHAR_W-1:0] pat     [MAX_PATTERN];
  logic [CHAR_W-1:0] win     [MAX_PATTERN];
  logic [CHAR_W-1:0] win_next[MAX_PATTERN];
  logic [MAX_PATTERN-1:0] diff;
  logic append_ok;

  assign append_ok = step && (item.cmd == CMD_APPEND) && (plen < LEN_W'(MAX_PATTERN));

  always_comb begin
    win_next[0] = item.ch;
    for (int k = 1; k < MAX_PATTERN; k++) begin
      win_next[k] = win[k-1];
    end
    for (int k = 0; k < MAX_PATTERN; k++) begin
      diff[k] = (pat[k] != win_next[k]) && (plen > LEN_W'(k));
    end
  end

  // Clear the lowest set bit: anything left means two or more differences.
  assign cmp.diff_any   = |diff;
  assign cmp.diff_multi = |(diff & (diff - MAX_PATTERN'(1)));

  always_ff @(posedge clk) begin
    if (append_ok) begin
      pat[0] <= item.ch;
      for (int k = 1; k < MAX_PATTERN; k++) begin
        pat[k] <= pat[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      plen <= '0;
      for (int k = 0; k < MAX_PATTERN; k++) begin
        win[k] <= '0;
      end
    end else if (step) begin
      case (item.cmd)
        CMD_CLEAR: begin
          plen <= '0;
        end
        CMD_APPEND: begin
          if (append_ok) begin
            plen <= plen + LEN_W'(1);
          end
        end
        CMD_TEXT: begin
          for (int k = 0; k < MAX_PATTERN; k++) begin
            win[k] <= win_next[k];
          end
        end
        CMD_END: begin
          for (int k = 0; k < MAX_PATTERN; k++) begin
            win[k] <= '0;
          end
        end
        default: begin
          plen <= plen;
        end
      endcase
    end
  end

endmodule

FILE: sv/omsm_track.sv
// ---------------------------------------------------------------------------
// Text position tracker
// Counts text bytes, saturates at the position limit, keeps the found flag
// and forms the result item for the current command.
// ---------------------------------------------------------------------------
module omsm_track #(
  parameter longint MAX_TEXT = omsm_pkg::MAX_TEXT_DEF,
  parameter int     LEN_W    = $clog2(omsm_pkg::MAX_PATTERN_DEF + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  omsm_pkg::cmd_t      cmd,
  input  logic [LEN_W-1:0]    plen,
  input  omsm_pkg::cmp_t      cmp,
  output logic                res_valid,
  output omsm_pkg::result_t   res
);
  import omsm_pkg::*;

  localparam longint POS_MAX = (longint'(1) << POS_W) - 1;
  localparam logic [POS_W-1:0] POS_LIMIT =
    (MAX_TEXT - 1 < POS_MAX) ? POS_W'(MAX_TEXT - 1) : POS_W'(POS_MAX);

  logic [POS_W-1:0] text_count;
  logic             count_saturated;
  logic             found_flag;
  logic             filled;
  logic             hit;
  logic [POS_W-1:0] start_pos;

  assign filled = count_saturated ||
                  ((POS_W+1)'(text_count) + (POS_W+1)'(1) >= (POS_W+1)'(plen));
  assign hit = (cmd == CMD_TEXT) && (plen != '0) && filled && !cmp.diff_multi;
  assign start_pos = count_saturated ? POS_LIMIT
                                     : text_count + POS_W'(1) - POS_W'(plen);

  always_comb begin
    res_valid = hit || (cmd == CMD_END);
    if (cmd == CMD_END) begin
      res.kind              = KIND_SUMMARY;
      res.position          = '0;
      res.mismatches        = 1'b0;
      res.any_match         = found_flag;
      res.position_overflow = count_saturated;
    end else begin
      res.kind              = KIND_MATCH;
      res.position          = start_pos;
      res.mismatches        = cmp.diff_any;
      res.any_match         = 1'b0;
      res.position_overflow = count_saturated;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      text_count      <= '0;
      count_saturated <= 1'b0;
      found_flag      <= 1'b0;
    end else if (step) begin
      case (cmd)
        CMD_TEXT: begin
          if (hit) begin
            found_flag <= 1'b1;
          end
          if (!count_saturated) begin
            if (text_count >= POS_LIMIT) begin
              count_saturated <= 1'b1;
            end else begin
              text_count <= text_count + POS_W'(1);
            end
          end
        end
        CMD_END: begin
          text_count      <= '0;
          count_saturated <= 1'b0;
          found_flag      <= 1'b0;
        end
        default: begin
          text_count <= text_count;
        end
      endcase
    end
  end

endmodule

FILE: sv/one_mismatch_string_matcher.sv
// A command item is held in the input register; its result item goes to the
// result register, and every window position is compared with the pattern
// between the two. Throughput: one item per cycle unless a result is stalled.
// Reset (synchronous, rst high): clears pattern length, text window, position
// counter, saturation and found flags and both handshake stages; pattern bytes
// keep their contents until appended again.
// ---------------------------------------------------------------------------
// One-mismatch string matcher
// Streams text against a loaded pattern and reports windows that differ from
// it in at most one byte, with an end-of-text summary.
// ---------------------------------------------------------------------------
`include "one_mismatch_string_matcher_macros.svh"

module one_mismatch_string_matcher #(
  parameter int     MAX_PATTERN = omsm_pkg::MAX_PATTERN_DEF,
  parameter longint MAX_TEXT    = omsm_pkg::MAX_TEXT_DEF
) (
  input  logic          clk,
  input  logic          rst,
  omsm_in_if.sink       item,
  omsm_out_if.source    result
);
  import omsm_pkg::*;

  localparam int LEN_W = $clog2(MAX_PATTERN + 1);

  logic             stage_valid;
  item_t            stage_item;
  logic             out_valid;
  result_t          out_res;
  logic             advance;
  logic             res_valid;
  result_t          res;
  logic [LEN_W-1:0] plen;
  cmp_t             cmp;

  // An item with no result may leave even while the result register is full.
  assign advance    = stage_valid && (!res_valid || !out_valid || result.ready);
  assign item.ready = !stage_valid || advance;

  omsm_store #(
    .MAX_PATTERN (MAX_PATTERN),
    .LEN_W       (LEN_W)
  ) u_store (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .item (stage_item),
    .plen (plen),
    .cmp  (cmp)
  );

  omsm_track #(
    .MAX_TEXT (MAX_TEXT),
    .LEN_W    (LEN_W)
  ) u_track (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .cmd       (stage_item.cmd),
    .plen      (plen),
    .cmp       (cmp),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (item.valid && item.ready) begin
      stage_valid <= 1'b1;
    end else if (advance) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      stage_item.cmd <= item.cmd;
      stage_item.ch  <= item.char_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && res_valid) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_res <= res;
    end
  end

  assign result.valid             = out_valid;
  assign result.kind              = out_res.kind;
  assign result.position          = out_res.position;
  assign result.mismatches        = out_res.mismatches;
  assign result.any_match         = out_res.any_match;
  assign result.position_overflow = out_res.position_overflow;

  `OMSM_ASSERT(a_stall_blocks_input, stage_valid && !advance |-> !item.ready, "input taken while stage stalled")
  `OMSM_ASSERT(a_match_no_summary, out_valid && out_res.kind == KIND_MATCH |-> !out_res.any_match, "match report carries summary flag")
  `OMSM_ASSERT(a_summary_fields, out_valid && out_res.kind == KIND_SUMMARY |-> out_res.position == '0 && !out_res.mismatches, "summary with nonzero position or mismatches")
  `OMSM_ASSERT(a_held_result, out_valid && !result.ready && !rst |=> out_valid && $stable(out_res), "pending result lost or changed")
  `OMSM_ASSERT(a_plen_range, plen <= LEN_W'(MAX_PATTERN), "pattern length beyond capacity")
  `OMSM_ASSERT_ALWAYS(a_reset_idle, rst |=> !result.valid && item.ready, "handshake not idle after reset")

endmodule

FILE: dv/testbench.sv
// ---------------------------------------------------------------------------
// One-mismatch string matcher testbench
// Loads patterns and streams text through the matcher with random idle
// cycles on both channels. An in-bench model predicts every match report and
// end-of-text summary; each result item is checked field by field in order.
// ---------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import omsm_pkg::*;

  localparam int          PAT_DEPTH = MAX_PATTERN_DEF;
  localparam int unsigned POS_MAX   =
    int'((MAX_TEXT_DEF - 1 < 65535) ? MAX_TEXT_DEF - 1 : 65535);
  localparam int          WATCHDOG  = 2000;
  localparam int          HOLD_LEN  = 300;
  localparam int          N_RANDOM  = 770;

  logic clk = 1'b0;
  logic rst = 1'b1;

  omsm_in_if  item_bus ();
  omsm_out_if result_bus ();

  one_mismatch_string_matcher DUT (
    .clk    (clk),
    .rst    (rst),
    .item   (item_bus),
    .result (result_bus)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Matcher state as predicted from the accepted items
  logic [7:0]  pat_mem [PAT_DEPTH];
  int unsigned pat_len;
  logic [7:0]  txt_win [PAT_DEPTH];
  int unsigned txt_next;
  bit          txt_sat;
  bit          any_found;

  result_t expected_results [$];

  bit idle_on;
  int stall_left;
  int hold_left;
  int errors;
  int n_sent;
  int n_in;
  int n_match;
  int n_near;
  int n_summary;

  function automatic bit predict_item(cmd_t c, logic [7:0] ch, output result_t r);
    bit          hit;
    bit          ovf;
    int unsigned idx;
    int unsigned diff;
    r   = '0;
    hit = 1'b0;
    case (c)
      CMD_CLEAR: begin
        pat_len = 0;
      end
      CMD_APPEND: begin
        if (pat_len < PAT_DEPTH) begin
          pat_mem[pat_len] = ch;
          pat_len++;
        end
      end
      CMD_TEXT: begin
        ovf = txt_sat;
        idx = txt_next;
        for (int k = PAT_DEPTH - 1; k > 0; k--) txt_win[k] = txt_win[k-1];
        txt_win[0] = ch;
        if (pat_len > 0 && (ovf || idx + 1 >= pat_len)) begin
          diff = 0;
          for (int j = 0; j < pat_len; j++)
            if (pat_mem[j] != txt_win[pat_len-1-j]) diff++;
          if (diff <= 1) begin
            any_found           = 1'b1;
            r.kind              = KIND_MATCH;
            r.position          = ovf ? POS_MAX[POS_W-1:0] : POS_W'(idx + 1 - pat_len);
            r.mismatches        = diff[0];
            r.position_overflow = ovf;
            hit                 = 1'b1;
          end
        end
        // Saturate after the byte at the last index
        if (!ovf) begin
          if (idx >= POS_MAX) txt_sat = 1'b1;
          else txt_next++;
        end
      end
      CMD_END: begin
        r.kind              = KIND_SUMMARY;
        r.any_match         = any_found;
        r.position_overflow = txt_sat;
        hit                 = 1'b1;
        txt_next            = 0;
        txt_sat             = 1'b0;
        any_found           = 1'b0;
        for (int k = 0; k < PAT_DEPTH; k++) txt_win[k] = 8'h00;
      end
      default: begin
        hit = 1'b0;
      end
    endcase
    return hit;
  endfunction

  task automatic check_field(string name, logic [POS_W-1:0] want, logic [POS_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // Predict on every accepted item, check every accepted result
  always @(posedge clk) begin : monitor
    result_t want;
    result_t got;
    if (!rst) begin
      if (item_bus.valid && item_bus.ready) begin
        n_in++;
        if (predict_item(item_bus.cmd, item_bus.char_in, want))
          expected_results.insert(expected_results.size(), want);
      end
      if (result_bus.valid && result_bus.ready) begin
        got.kind              = result_bus.kind;
        got.position          = result_bus.position;
        got.mismatches        = result_bus.mismatches;
        got.any_match         = result_bus.any_match;
        got.position_overflow = result_bus.position_overflow;
        stall_left = idle_on ? $urandom_range(0, 4) : 0;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual %p", $time, got);
          errors++;
        end else begin
          want = expected_results.pop_front();
          check_field("kind", POS_W'(want.kind), POS_W'(got.kind));
          check_field("position", want.position, got.position);
          check_field("mismatches", POS_W'(want.mismatches), POS_W'(got.mismatches));
          check_field("any_match", POS_W'(want.any_match), POS_W'(got.any_match));
          check_field("position_overflow", POS_W'(want.position_overflow),
                      POS_W'(got.position_overflow));
          if (got.kind == KIND_SUMMARY) n_summary++;
          else n_match++;
          if (got.kind == KIND_MATCH && got.mismatches) n_near++;
        end
      end
    end
  end

  // Result side: stall per item, plus the long hold-off when requested
  initial begin
    result_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        result_bus.ready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        result_bus.ready <= 1'b0;
        if (result_bus.valid) stall_left--;
      end else begin
        result_bus.ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG) begin
      @(posedge clk);
      if ((item_bus.valid && item_bus.ready) || (result_bus.valid && result_bus.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("timeout: nothing accepted for %0d cycles", WATCHDOG);
    $display("one_mismatch_string_matcher test failed");
    $finish;
  end

  task automatic send_item(cmd_t c, logic [7:0] ch);
    int gap;
    gap = idle_on ? $urandom_range(0, 4) : 0;
    repeat (gap) begin
      @(negedge clk);
      item_bus.valid <= 1'b0;
    end
    @(negedge clk);
    item_bus.valid   <= 1'b1;
    item_bus.cmd     <= c;
    item_bus.char_in <= ch;
    do @(posedge clk); while (!item_bus.ready);
    n_sent++;
  endtask

  task automatic test_empty_pattern();
    send_item(CMD_CLEAR, 8'hFF);
    send_item(CMD_TEXT, 8'h00);
    send_item(CMD_TEXT, 8'hFF);
    send_item(CMD_END, 8'hFF);
  endtask

  task automatic test_exact_and_near();
    send_item(CMD_CLEAR, 8'h00);
    send_item(CMD_APPEND, 8'h00);
    send_item(CMD_APPEND, 8'hFF);
    send_item(CMD_APPEND, 8'hA5);
    send_item(CMD_TEXT, 8'h00);
    send_item(CMD_TEXT, 8'hFF);
    send_item(CMD_TEXT, 8'hA5);
    send_item(CMD_TEXT, 8'h00);
    send_item(CMD_TEXT, 8'hFF);
    send_item(CMD_TEXT, 8'h5A);
    send_item(CMD_TEXT, 8'h11);
    send_item(CMD_TEXT, 8'h22);
    send_item(CMD_TEXT, 8'h33);
    send_item(CMD_END, 8'h00);
    send_item(CMD_END, 8'h00);
  endtask

  task automatic test_short_text();
    send_item(CMD_CLEAR, 8'h00);
    for (int i = 0; i < 5; i++) send_item(CMD_APPEND, 8'(8'h30 + i));
    for (int i = 0; i < 3; i++) send_item(CMD_TEXT, 8'(8'h30 + i));
    send_item(CMD_END, 8'h00);
  endtask

  // Clearing the pattern keeps the text position and window
  task automatic test_clear_keeps_text();
    send_item(CMD_CLEAR, 8'h00);
    send_item(CMD_APPEND, 8'h42);
    send_item(CMD_TEXT, 8'h42);
    send_item(CMD_TEXT, 8'h17);
    send_item(CMD_CLEAR, 8'h00);
    send_item(CMD_APPEND, 8'h17);
    send_item(CMD_APPEND, 8'h43);
    send_item(CMD_TEXT, 8'h43);
    send_item(CMD_END, 8'h00);
  endtask

  // Appends past the last entry are dropped
  task automatic test_full_pattern();
    send_item(CMD_CLEAR, 8'h00);
    for (int i = 0; i < PAT_DEPTH + 2; i++) send_item(CMD_APPEND, 8'(i * 4 + i / 16));
    for (int i = 0; i < PAT_DEPTH; i++) send_item(CMD_TEXT, 8'(i * 4 + i / 16));
    send_item(CMD_TEXT, 8'h00);
    send_item(CMD_END, 8'h00);
    for (int i = 0; i < PAT_DEPTH; i++)
      send_item(CMD_TEXT, (i == 20) ? 8'hEE : 8'(i * 4 + i / 16));
    send_item(CMD_END, 8'h00);
  endtask

  // One-byte pattern matches every text byte, so results pile up
  task automatic test_backpressure();
    send_item(CMD_CLEAR, 8'h00);
    send_item(CMD_APPEND, 8'h61);
    hold_left = HOLD_LEN;
    for (int i = 0; i < 40; i++) send_item(CMD_TEXT, 8'($urandom));
    send_item(CMD_END, 8'h00);
  endtask

  // Mostly well-formed load/stream/end sequences, with some noise mixed in
  task automatic test_random_streams();
    logic [7:0] pat [PAT_DEPTH];
    int         plen;
    int         len;
    int         tlen;
    int         mut;
    int         target;
    logic [7:0] b;
    plen   = 0;
    target = n_sent + N_RANDOM;
    while (n_sent < target) begin
      if ($urandom_range(0, 9) == 0) begin
        send_item(cmd_t'($urandom_range(0, 3)), 8'($urandom));
        continue;
      end
      if (plen == 0 || $urandom_range(0, 3) != 0) begin
        send_item(CMD_CLEAR, 8'($urandom));
        len  = ($urandom_range(0, 7) == 0) ? $urandom_range(9, PAT_DEPTH + 2)
                                           : $urandom_range(1, 8);
        plen = (len > PAT_DEPTH) ? PAT_DEPTH : len;
        for (int i = 0; i < len; i++) begin
          b = 8'($urandom);
          if (i < PAT_DEPTH) pat[i] = b;
          send_item(CMD_APPEND, b);
        end
      end
      tlen = $urandom_range(0, 48);
      for (int i = 0; i < tlen; i++) begin
        if ($urandom_range(0, 5) == 0) begin
          // Drop in a copy of the pattern with zero, one or two bytes changed
          mut = $urandom_range(0, 2);
          for (int j = 0; j < plen; j++) begin
            b = pat[j];
            if (mut > 0 && j == plen - 1) b = ~b;
            if (mut > 1 && j == 0 && plen > 1) b = ~b;
            send_item(CMD_TEXT, b);
          end
        end else if ($urandom_range(0, 1) == 0) begin
          send_item(CMD_TEXT, pat[$urandom_range(0, plen - 1)]);
        end else begin
          send_item(CMD_TEXT, 8'($urandom));
        end
      end
      if ($urandom_range(0, 4) != 0) send_item(CMD_END, 8'($urandom));
    end
  endtask

  initial begin
    item_bus.valid   = 1'b0;
    item_bus.cmd     = CMD_CLEAR;
    item_bus.char_in = 8'h00;
    pat_len   = 0;
    txt_next  = 0;
    txt_sat   = 1'b0;
    any_found = 1'b0;
    for (int k = 0; k < PAT_DEPTH; k++) begin
      pat_mem[k] = 8'h00;
      txt_win[k] = 8'h00;
    end
    idle_on    = 1'b0;
    stall_left = 0;
    hold_left  = 0;
    errors     = 0;
    n_sent     = 0;
    n_in       = 0;
    n_match    = 0;
    n_near     = 0;
    n_summary  = 0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_pattern();
    idle_on = 1'b1;
    test_exact_and_near();
    test_short_text();
    test_clear_keeps_text();
    idle_on = 1'b0;
    test_full_pattern();
    idle_on = 1'b1;
    test_backpressure();
    test_random_streams();

    @(negedge clk);
    item_bus.valid <= 1'b0;
    wait (expected_results.size() == 0);
    repeat (8) @(posedge clk);

    $display("Sent %0d items: %0d match reports (%0d with one differing byte)", n_in,
             n_match, n_near);
    $display("  and %0d end-of-text summaries", n_summary);
    if (errors == 0) begin
      $display("one_mismatch_string_matcher test passed");
    end else begin
      $display("one_mismatch_string_matcher test failed");
    end
    $finish;
  end

endmodule
